>>> hdl/mbpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbpf_pkg
// Shared types and constants of the Modbus request frame builder.
// ----------------------------------------------------------------------------
package mbpf_pkg;

    localparam int unsigned MBPF_QUEUE_DEPTH = 4;
    localparam int unsigned CFG_IDX_W        = 3;
    localparam int unsigned CFG_DATA_W       = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_CODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVER_ID     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_READ_START    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_READ_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_START   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_COUNT   = 3'd5;

    // function codes
    localparam logic [7:0] FC_INVALID         = 8'd0;
    localparam logic [7:0] FC_READ_COILS      = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE   = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
    localparam logic [7:0] FC_READ_INPUT      = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
    localparam logic [7:0] FC_WRITE_REG       = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS      = 8'd16;
    localparam logic [7:0] FC_READ_WRITE_REGS = 8'd23;

    localparam logic [7:0] COIL_ON_BYTE  = 8'hff;
    localparam logic [7:0] COIL_OFF_BYTE = 8'h00;

    // header byte slots, in frame order
    localparam logic [3:0] SLOT_ID       = 4'd0;
    localparam logic [3:0] SLOT_FC       = 4'd1;
    localparam logic [3:0] SLOT_RS_HI    = 4'd2;
    localparam logic [3:0] SLOT_RS_LO    = 4'd3;
    localparam logic [3:0] SLOT_RC_HI    = 4'd4;
    localparam logic [3:0] SLOT_RC_LO    = 4'd5;
    localparam logic [3:0] SLOT_WS_HI    = 4'd6;
    localparam logic [3:0] SLOT_WS_LO    = 4'd7;
    localparam logic [3:0] SLOT_WC_HI    = 4'd8;
    localparam logic [3:0] SLOT_WC_LO    = 4'd9;
    localparam logic [3:0] SLOT_BCOUNT   = 4'd10;

    typedef struct packed {
        logic [7:0]  function_code;
        logic [7:0]  server_id;
        logic [15:0] read_start;
        logic [15:0] read_count;
        logic [15:0] write_start;
        logic [15:0] write_count;
    } t_cfg;

    typedef enum logic [2:0] {
        K_DATA    = 3'd0,
        K_READ    = 3'd1,
        K_SINGLE  = 3'd2,
        K_MULTI   = 3'd3,
        K_RW      = 3'd4,
        K_UNKNOWN = 3'd5
    } t_kind;

    // one unit of work for the serializer
    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two;    // data job carries two bytes
        logic       last;   // job closes the frame
    } t_job;

endpackage : mbpf_pkg
`default_nettype wire

>>> hdl/mbpf_intf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbpf interfaces
// Request, byte and configuration channels of the frame builder.
// ----------------------------------------------------------------------------
interface mbpf_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] value_word;
    logic        final_value;
    logic        no_values;

    modport source (output valid, req_type, value_word, final_value, no_values,
                    input ready);
    modport sink   (input valid, req_type, value_word, final_value, no_values,
                    output ready);
endinterface : mbpf_req_if

interface mbpf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, data_byte, frame_end, input ready);
    modport sink   (input valid, data_byte, frame_end, output ready);
endinterface : mbpf_rsp_if

interface mbpf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface : mbpf_cfg_if
`default_nettype wire

>>> hdl/mbpf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbpf_front
// Accepts request items, tracks frame state and issues serializer jobs.
// ----------------------------------------------------------------------------
module mbpf_front
    import mbpf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    mbpf_req_if.sink  i_req,
    input  wire logic i_q_full,
    output logic      o_push,
    output t_job      o_job
);

    logic       r_active, n_active;
    logic       r_single, n_single;
    logic [7:0] r_acc, n_acc;
    logic [2:0] r_pos, n_pos;

    logic       accept;
    logic       v_on;
    logic [7:0] acc_set;
    logic [2:0] pos_inc;

    assign i_req.ready = !i_q_full;
    assign accept      = i_req.valid && !i_q_full;
    assign v_on        = |i_req.value_word;
    assign acc_set     = r_acc | (v_on ? (8'd1 << r_pos) : 8'd0);
    assign pos_inc     = r_pos + 3'd1;

    always_comb begin
        n_active = r_active;
        n_single = r_single;
        n_acc    = r_acc;
        n_pos    = r_pos;
        o_push   = 1'b0;
        o_job    = '{kind: K_DATA, byte0: 8'd0, byte1: 8'd0, two: 1'b0, last: 1'b0};
        if (accept) begin
            if (!i_req.req_type) begin
                n_active = 1'b0;
                n_single = 1'b0;
                n_acc    = 8'd0;
                n_pos    = 3'd0;
                o_job.last = 1'b1;
                case (i_cfg.function_code)
                    FC_INVALID: begin
                        o_push = 1'b0;
                    end
                    FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT: begin
                        o_push     = 1'b1;
                        o_job.kind = K_READ;
                    end
                    FC_WRITE_COIL, FC_WRITE_REG: begin
                        o_push     = 1'b1;
                        o_job.kind = K_SINGLE;
                        o_job.last = i_req.no_values;
                        n_active   = !i_req.no_values;
                    end
                    FC_WRITE_COILS, FC_WRITE_REGS: begin
                        o_push     = 1'b1;
                        o_job.kind = K_MULTI;
                        o_job.last = i_req.no_values;
                        n_active   = !i_req.no_values;
                    end
                    FC_READ_WRITE_REGS: begin
                        o_push     = 1'b1;
                        o_job.kind = K_RW;
                        o_job.last = i_req.no_values;
                        n_active   = !i_req.no_values;
                    end
                    default: begin
                        o_push     = 1'b1;
                        o_job.kind = K_UNKNOWN;
                    end
                endcase
            end else if (r_active) begin
                case (i_cfg.function_code)
                    FC_WRITE_COIL: begin
                        if (!r_single) begin
                            o_push      = 1'b1;
                            o_job.byte0 = v_on ? COIL_ON_BYTE : COIL_OFF_BYTE;
                            o_job.byte1 = 8'h00;
                            o_job.two   = 1'b1;
                            o_job.last  = 1'b1;
                            n_single    = 1'b1;
                            n_active    = 1'b0;
                        end
                    end
                    FC_WRITE_REG: begin
                        if (!r_single) begin
                            o_push      = 1'b1;
                            o_job.byte0 = i_req.value_word[15:8];
                            o_job.byte1 = i_req.value_word[7:0];
                            o_job.two   = 1'b1;
                            o_job.last  = 1'b1;
                            n_single    = 1'b1;
                            n_active    = 1'b0;
                        end
                    end
                    FC_WRITE_COILS: begin
                        // pack LSB first; flush on a full byte or the final value
                        n_acc = acc_set;
                        n_pos = pos_inc;
                        if (i_req.final_value || pos_inc == 3'd0) begin
                            o_push      = 1'b1;
                            o_job.byte0 = acc_set;
                            o_job.last  = i_req.final_value;
                            n_acc       = 8'd0;
                            n_pos       = 3'd0;
                        end
                        if (i_req.final_value) begin
                            n_active = 1'b0;
                        end
                    end
                    FC_WRITE_REGS, FC_READ_WRITE_REGS: begin
                        o_push      = 1'b1;
                        o_job.byte0 = i_req.value_word[15:8];
                        o_job.byte1 = i_req.value_word[7:0];
                        o_job.two   = 1'b1;
                        o_job.last  = i_req.final_value;
                        if (i_req.final_value) begin
                            n_active = 1'b0;
                        end
                    end
                    default: begin
                        o_push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_single <= 1'b0;
            r_acc    <= 8'd0;
            r_pos    <= 3'd0;
        end else begin
            r_active <= n_active;
            r_single <= n_single;
            r_acc    <= n_acc;
            r_pos    <= n_pos;
        end
    end

endmodule : mbpf_front
`default_nettype wire

>>> hdl/mbpf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbpf_queue
// Small job FIFO between the front end and the byte serializer.
// ----------------------------------------------------------------------------
module mbpf_queue
    import mbpf_pkg::*;
#(
    parameter int unsigned DEPTH = MBPF_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_job      o_head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule : mbpf_queue
`default_nettype wire

>>> hdl/mbpf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbpf_back
// Serializes queued jobs into frame bytes through an output register.
// ----------------------------------------------------------------------------
module mbpf_back
    import mbpf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_q_empty,
    input  wire t_job i_head,
    output logic      o_pop,
    mbpf_rsp_if.source o_rsp
);

    logic [3:0]  r_idx, n_idx;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_end;

    logic [3:0]  last_idx;
    logic [3:0]  next_idx;
    logic        is_last;
    logic        load;
    logic [7:0]  cur_byte;
    logic [7:0]  hdr_byte;
    logic [7:0]  bcount;
    logic [16:0] coil_round;

    assign coil_round = {1'b0, i_cfg.write_count} + 17'd7;
    assign bcount     = (i_cfg.function_code == FC_WRITE_COILS) ? coil_round[10:3]
                                                                : {i_cfg.write_count[6:0], 1'b0};

    always_comb begin
        case (r_idx)
            SLOT_ID:     hdr_byte = i_cfg.server_id;
            SLOT_FC:     hdr_byte = i_cfg.function_code;
            SLOT_RS_HI:  hdr_byte = i_cfg.read_start[15:8];
            SLOT_RS_LO:  hdr_byte = i_cfg.read_start[7:0];
            SLOT_RC_HI:  hdr_byte = i_cfg.read_count[15:8];
            SLOT_RC_LO:  hdr_byte = i_cfg.read_count[7:0];
            SLOT_WS_HI:  hdr_byte = i_cfg.write_start[15:8];
            SLOT_WS_LO:  hdr_byte = i_cfg.write_start[7:0];
            SLOT_WC_HI:  hdr_byte = i_cfg.write_count[15:8];
            SLOT_WC_LO:  hdr_byte = i_cfg.write_count[7:0];
            SLOT_BCOUNT: hdr_byte = bcount;
            default:     hdr_byte = 8'd0;
        endcase
    end

    always_comb begin
        case (i_head.kind)
            K_DATA:    last_idx = i_head.two ? 4'd1 : 4'd0;
            K_READ:    last_idx = SLOT_RC_LO;
            K_SINGLE:  last_idx = SLOT_WS_LO;
            K_MULTI:   last_idx = SLOT_BCOUNT;
            K_RW:      last_idx = SLOT_BCOUNT;
            K_UNKNOWN: last_idx = SLOT_FC;
            default:   last_idx = 4'd0;
        endcase
    end

    // write-only headers skip the read address and count
    assign next_idx = (r_idx == SLOT_FC && (i_head.kind == K_SINGLE || i_head.kind == K_MULTI))
                      ? SLOT_WS_HI : r_idx + 4'd1;
    assign is_last  = (r_idx == last_idx);
    assign cur_byte = (i_head.kind == K_DATA) ? (r_idx[0] ? i_head.byte1 : i_head.byte0)
                                              : hdr_byte;
    assign load     = !i_q_empty && (!r_valid || o_rsp.ready);
    assign o_pop    = load && is_last;
    assign n_idx    = load ? (is_last ? 4'd0 : next_idx) : r_idx;

    assign o_rsp.valid     = r_valid;
    assign o_rsp.data_byte = r_byte;
    assign o_rsp.frame_end = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= cur_byte;
            r_end  <= is_last && i_head.last;
        end
    end

endmodule : mbpf_back
`default_nettype wire

>>> hdl/modbus_request_pdu_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_request_pdu_framer
// Builds Modbus request frames as a byte stream from start and value items.
// ----------------------------------------------------------------------------
// A start item emits the frame header for the configured function code:
// 2 bytes for an unknown code, 6 for reads, 4 for single writes, 7 for
// multiple writes and 11 for read/write multiple registers; code 0 emits
// nothing. Each register value then emits 2 bytes, a single coil 2 bytes,
// and multiple coils 1 byte per eight values plus a flush on the final one.
// While the receiver is ready, the output register moves one byte per
// cycle. Items enter a small job queue (QUEUE_DEPTH jobs) whenever it has
// room, so input and output stall independently. Configuration writes are
// taken at any time but must only be issued while no frame bytes are pending.
module modbus_request_pdu_framer
    import mbpf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = MBPF_QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mbpf_cfg_if.sink   i_cfg,
    mbpf_req_if.sink   i_req,
    mbpf_rsp_if.source o_rsp
);

    t_cfg r_cfg;
    logic q_full, q_empty, push, pop;
    t_job push_job, head_job;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_FUNCTION_CODE: r_cfg.function_code <= i_cfg.data[7:0];
                REG_SERVER_ID:     r_cfg.server_id     <= i_cfg.data[7:0];
                REG_READ_START:    r_cfg.read_start    <= i_cfg.data;
                REG_READ_COUNT:    r_cfg.read_count    <= i_cfg.data;
                REG_WRITE_START:   r_cfg.write_start   <= i_cfg.data;
                REG_WRITE_COUNT:   r_cfg.write_count   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    mbpf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    mbpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    mbpf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_head    (head_job),
        .o_pop     (pop),
        .o_rsp     (o_rsp)
    );

endmodule : modbus_request_pdu_framer
`default_nettype wire

>>> tb/sv/modbus_request_pdu_framer_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_request_pdu_framer_tb
// Self-checking bench for the Modbus request frame builder.
// ----------------------------------------------------------------------------
// Runs a set of directed setups (each kind of function code, register extremes,
// restarts, frames left open across a code change), then random setups made
// mostly of well-formed frames. A local model predicts each frame byte when a
// request transaction is taken, and the byte monitor checks every output byte
// in order. The sender runs in random bursts, the receiver stalls on its own
// pattern and once holds off long enough to back the block up.
module modbus_request_pdu_framer_tb;
    import mbpf_pkg::*;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_VALUE = 1'b1;
    localparam logic [7:0] FC_UNLISTED = 8'hFF;

    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned PHASE_ITEMS    = 14;
    localparam int unsigned RANDOM_PHASES  = 8;
    localparam int unsigned HOLD_AT        = 60;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic        req_type;
        logic [15:0] value_word;
        logic        final_value;
        logic        no_values;
    } t_pdu_req;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_frame_byte;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_THIRD,
        RX_MOSTLY
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mbpf_cfg_if cfg_bus ();
    mbpf_req_if req_bus ();
    mbpf_rsp_if rsp_bus ();

    modbus_request_pdu_framer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always #1 i_clk = ~i_clk;

    // mirrored registers and frame state
    t_cfg        shadow_cfg;
    logic [7:0]  coil_acc;
    logic [2:0]  coil_bit;
    logic        single_sent;
    logic        frame_open;

    t_pdu_req    pending_reqs[$];
    t_frame_byte frame_bytes_due[$];
    t_pdu_req    offered_req;

    int unsigned items_queued = 0;
    int unsigned req_taken    = 0;
    int unsigned bytes_seen   = 0;
    int unsigned cfg_writes   = 0;
    int unsigned setups       = 0;
    int unsigned err_count    = 0;

    // ------------------------------------------------------------------
    // frame prediction
    // ------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] b, input logic last);
        frame_bytes_due.push_back('{data_byte: b, frame_end: last});
    endfunction

    function automatic void push_word(input logic [15:0] w, input logic last);
        push_byte(w[15:8], 1'b0);
        push_byte(w[7:0], last);
    endfunction

    function automatic void predict_header(input logic none);
        logic [7:0]  fc;
        logic [16:0] coil_bytes;
        fc          = shadow_cfg.function_code;
        frame_open  = 1'b0;
        single_sent = 1'b0;
        coil_acc    = 8'h00;
        coil_bit    = 3'd0;
        if (fc == FC_INVALID) return;
        push_byte(shadow_cfg.server_id, 1'b0);
        case (fc)
            FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT: begin
                push_byte(fc, 1'b0);
                push_word(shadow_cfg.read_start, 1'b0);
                push_word(shadow_cfg.read_count, 1'b1);
            end
            FC_WRITE_COIL, FC_WRITE_REG: begin
                push_byte(fc, 1'b0);
                push_word(shadow_cfg.write_start, none);
                frame_open = !none;
            end
            FC_WRITE_COILS, FC_WRITE_REGS, FC_READ_WRITE_REGS: begin
                push_byte(fc, 1'b0);
                if (fc == FC_READ_WRITE_REGS) begin
                    push_word(shadow_cfg.read_start, 1'b0);
                    push_word(shadow_cfg.read_count, 1'b0);
                end
                push_word(shadow_cfg.write_start, 1'b0);
                push_word(shadow_cfg.write_count, 1'b0);
                if (fc == FC_WRITE_COILS) begin
                    coil_bytes = ({1'b0, shadow_cfg.write_count} + 17'd7) >> 3;
                    push_byte(coil_bytes[7:0], none);
                end else begin
                    push_byte({shadow_cfg.write_count[6:0], 1'b0}, none);
                end
                frame_open = !none;
            end
            default: push_byte(fc, 1'b1);
        endcase
    endfunction

    function automatic void predict_value_bytes(input logic [15:0] v, input logic fin);
        if (!frame_open) return;
        case (shadow_cfg.function_code)
            FC_WRITE_COIL: begin
                if (!single_sent) begin
                    push_byte((v != 16'h0000) ? COIL_ON_BYTE : COIL_OFF_BYTE, 1'b0);
                    push_byte(8'h00, 1'b1);
                    single_sent = 1'b1;
                    frame_open  = 1'b0;
                end
            end
            FC_WRITE_REG: begin
                if (!single_sent) begin
                    push_word(v, 1'b1);
                    single_sent = 1'b1;
                    frame_open  = 1'b0;
                end
            end
            FC_WRITE_COILS: begin
                if (v != 16'h0000) coil_acc[coil_bit] = 1'b1;
                coil_bit = coil_bit + 3'd1;
                if (fin || coil_bit == 3'd0) begin
                    push_byte(coil_acc, fin);
                    coil_acc = 8'h00;
                    coil_bit = 3'd0;
                end
                if (fin) frame_open = 1'b0;
            end
            FC_WRITE_REGS, FC_READ_WRITE_REGS: begin
                push_word(v, fin);
                if (fin) frame_open = 1'b0;
            end
            default: ;  // code no longer takes values: dropped, frame stays open
        endcase
    endfunction

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid       <= 1'b0;
            req_bus.req_type    <= REQ_START;
            req_bus.value_word  <= 16'h0000;
            req_bus.final_value <= 1'b0;
            req_bus.no_values   <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                if (offered_req.req_type == REQ_START)
                    predict_header(offered_req.no_values);
                else
                    predict_value_bytes(offered_req.value_word, offered_req.final_value);
                req_taken++;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    req_bus.valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    offered_req = pending_reqs.pop_front();
                    req_bus.valid       <= 1'b1;
                    req_bus.req_type    <= offered_req.req_type;
                    req_bus.value_word  <= offered_req.value_word;
                    req_bus.final_value <= offered_req.final_value;
                    req_bus.no_values   <= offered_req.no_values;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 8);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // byte monitor and receiver stalls
    // ------------------------------------------------------------------
    t_rx_mode    rx_mode    = RX_OPEN;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    int unsigned rx_tick    = 0;
    logic        hold_done  = 1'b0;
    t_frame_byte want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                bytes_seen++;
                if (frame_bytes_due.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected byte: expected none, got %02h end %0b",
                             $time, rsp_bus.data_byte, rsp_bus.frame_end);
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (rsp_bus.data_byte !== want.data_byte) begin
                        err_count++;
                        $display("%0t: data_byte mismatch: expected %02h, got %02h",
                                 $time, want.data_byte, rsp_bus.data_byte);
                    end
                    if (rsp_bus.frame_end !== want.frame_end) begin
                        err_count++;
                        $display("%0t: frame_end mismatch: expected %0b, got %0b",
                                 $time, want.frame_end, rsp_bus.frame_end);
                    end
                end
            end

            rx_tick++;
            // one long hold-off while requests keep coming
            if (!hold_done && req_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 80);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_OPEN:   rsp_bus.ready <= 1'b1;
                    RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
                    RX_THIRD:  rsp_bus.ready <= (rx_tick % 3 == 0);
                    default:   rsp_bus.ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: cycles without any transaction
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d bytes still due",
                     $time, WATCHDOG_LIMIT, frame_bytes_due.size());
            $display("modbus_request_pdu_framer_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_writes++;
        case (idx)
            REG_FUNCTION_CODE: shadow_cfg.function_code = val[7:0];
            REG_SERVER_ID:     shadow_cfg.server_id     = val[7:0];
            REG_READ_START:    shadow_cfg.read_start    = val;
            REG_READ_COUNT:    shadow_cfg.read_count    = val;
            REG_WRITE_START:   shadow_cfg.write_start   = val;
            REG_WRITE_COUNT:   shadow_cfg.write_count   = val;
            default: ;
        endcase
    endtask

    // called on a rising edge with the block idle; returns on a falling edge
    task automatic apply_config(input logic [7:0] fc, input logic [7:0] id,
                                input logic [15:0] rs, input logic [15:0] rc,
                                input logic [15:0] ws, input logic [15:0] wc);
        write_reg(REG_FUNCTION_CODE, {8'h00, fc});
        write_reg(REG_SERVER_ID, {8'h00, id});
        write_reg(REG_READ_START, rs);
        write_reg(REG_READ_COUNT, rc);
        write_reg(REG_WRITE_START, ws);
        write_reg(REG_WRITE_COUNT, wc);
        cfg_bus.valid <= 1'b0;
        setups++;
        @(negedge i_clk);
    endtask

    function automatic void queue_item(input logic kind, input logic [15:0] word,
                                       input logic fin, input logic none);
        pending_reqs.push_back('{req_type: kind, value_word: word,
                                 final_value: fin, no_values: none});
        items_queued++;
    endfunction

    // wait for every request taken and every byte out, then let the job
    // queue run dry before touching registers
    task automatic settle();
        while (items_queued != req_taken || frame_bytes_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int unsigned idx);
        logic [7:0]  fc;
        logic [15:0] regs [5];
        logic [15:0] word;
        logic        none;
        int unsigned counted;
        int unsigned n;
        int unsigned k;
        case (idx % 8)
            0, 5:    fc = FC_WRITE_COILS;
            1:       fc = FC_WRITE_REGS;
            2:       fc = FC_READ_WRITE_REGS;
            3:       fc = FC_WRITE_COIL;
            4:       fc = FC_WRITE_REG;
            6:       fc = 8'($urandom_range(1, 4));
            default: begin
                fc = 8'($urandom_range(0, 255));
                if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) fc = FC_UNLISTED;
            end
        endcase
        for (int i = 0; i < 5; i++)
            regs[i] = (idx == 0) ? 16'hFFFF : (idx == 1) ? 16'h0000 : pick_word();
        apply_config(fc, regs[0][7:0], regs[1], regs[2], regs[3], regs[4]);

        counted = 0;
        while (counted < PHASE_ITEMS) begin
            k = $urandom_range(0, 9);
            if (k == 0) begin
                // stray value, usually outside a frame
                queue_item(REQ_VALUE, 16'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                none = ($urandom_range(0, 7) == 0);
                queue_item(REQ_START, 16'($urandom), 1'($urandom), none);
                counted++;
                case (fc)
                    FC_WRITE_COILS:                    n = $urandom_range(1, 20);
                    FC_WRITE_COIL, FC_WRITE_REG:       n = $urandom_range(1, 2);
                    FC_WRITE_REGS, FC_READ_WRITE_REGS: n = $urandom_range(1, 6);
                    default:                           n = 0;
                endcase
                if (none) n = 0;
                for (int j = 1; j <= n; j++) begin
                    if (fc == FC_WRITE_COILS)
                        word = $urandom_range(0, 1) ? 16'h0000 : 16'($urandom);
                    else
                        word = 16'($urandom);
                    // k == 1: frame broken off, no final value
                    queue_item(REQ_VALUE, word, (j == n) && (k != 1), 1'b0);
                end
                counted += n;
            end
        end
        settle();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_FUNCTION_CODE;
        cfg_bus.data  = 16'h0000;
        shadow_cfg    = '0;
        coil_acc      = 8'h00;
        coil_bit      = 3'd0;
        single_sent   = 1'b0;
        frame_open    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // invalid code: nothing out, stray value ignored
        apply_config(FC_INVALID, 8'hFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        queue_item(REQ_START, 16'hFFFF, 1'b1, 1'b1);
        queue_item(REQ_VALUE, 16'h1234, 1'b1, 1'b0);
        settle();

        apply_config(FC_READ_HOLDING, 8'h00, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        queue_item(REQ_START, 16'h0000, 1'b0, 1'b0);
        settle();

        // single coil off and on, then header only
        apply_config(FC_WRITE_COIL, 8'h11, 16'h0102, 16'h0003, 16'hA55A, 16'h0001);
        queue_item(REQ_START, 16'h0000, 1'b0, 1'b0);
        queue_item(REQ_VALUE, 16'h0000, 1'b1, 1'b0);
        queue_item(REQ_START, 16'h0000, 1'b0, 1'b0);
        queue_item(REQ_VALUE, 16'h8000, 1'b0, 1'b0);
        queue_item(REQ_START, 16'h0000, 1'b0, 1'b1);
        settle();

        apply_config(FC_WRITE_REG, 8'h7E, 16'h0000, 16'h0000, 16'hFFFF, 16'h0002);
        queue_item(REQ_START, 16'h0000, 1'b0, 1'b1);
        queue_item(REQ_START, 16'h0000, 1'b0, 1'b0);
        queue_item(REQ_VALUE, 16'hFFFF, 1'b1, 1'b0);
        settle();

        // byte count of 8192 wraps to zero; partial coil byte flushed
        apply_config(FC_WRITE_COILS, 8'h5A, 16'h0000, 16'h0000, 16'h00C8, 16'hFFFF);
        queue_item(REQ_START, 16'h0000, 1'b0, 1'b0);
        queue_item(REQ_VALUE, 16'h0001, 1'b0, 1'b0);
        queue_item(REQ_VALUE, 16'h0000, 1'b0, 1'b0);
        queue_item(REQ_VALUE, 16'hFFFF, 1'b1, 1'b0);
        settle();

        // 2 * 128 registers wraps the byte count to zero
        apply_config(FC_WRITE_REGS, 8'hA5, 16'h0000, 16'h0000, 16'h0000, 16'h0080);
        queue_item(REQ_START, 16'h0000, 1'b0, 1'b0);
        queue_item(REQ_VALUE, 16'h0000, 1'b0, 1'b0);
        queue_item(REQ_VALUE, 16'hFFFF, 1'b1, 1'b0);
        settle();

        apply_config(FC_READ_WRITE_REGS, 8'h01, 16'h1234, 16'h0005, 16'hFFFF, 16'h007B);
        queue_item(REQ_START, 16'h0000, 1'b0, 1'b1);
        settle();

        apply_config(FC_UNLISTED, 8'hFE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_item(REQ_START, 16'h0000, 1'b0, 1'b0);
        settle();

        // restart mid-frame, then leave the frame open across code changes
        apply_config(FC_WRITE_REGS, 8'h3C, 16'h0000, 16'h0000, 16'h0010, 16'h0002);
        queue_item(REQ_START, 16'h0000, 1'b0, 1'b0);
        queue_item(REQ_VALUE, 16'hBEEF, 1'b0, 1'b0);
        queue_item(REQ_START, 16'h0000, 1'b0, 1'b0);
        queue_item(REQ_VALUE, 16'h0F0F, 1'b0, 1'b0);
        settle();

        apply_config(FC_READ_COILS, 8'h3C, 16'h0000, 16'h0000, 16'h0010, 16'h0002);
        queue_item(REQ_VALUE, 16'h4321, 1'b1, 1'b0);
        settle();

        apply_config(FC_WRITE_COILS, 8'h3C, 16'h0000, 16'h0000, 16'h0010, 16'h0002);
        queue_item(REQ_VALUE, 16'h0001, 1'b1, 1'b0);
        settle();

        for (int unsigned p = 0; p < RANDOM_PHASES; p++)
            random_phase(p);

        $display("%0d requests over %0d register setups (%0d register writes)",
                 req_taken, setups, cfg_writes);
        $display("%0d frame bytes checked, with a long output hold-off and idle drains",
                 bytes_seen);
        if (err_count == 0) begin
            $display("modbus_request_pdu_framer_tb: clean");
        end else begin
            $display("modbus_request_pdu_framer_tb: errors");
        end
        $finish;
    end

endmodule : modbus_request_pdu_framer_tb
`default_nettype wire

>>> files.f
hdl/mbpf_pkg.sv
hdl/mbpf_intf.sv
hdl/mbpf_front.sv
hdl/mbpf_queue.sv
hdl/mbpf_back.sv
hdl/modbus_request_pdu_framer.sv
tb/sv/modbus_request_pdu_framer_tb.sv
